### rtl/pbps_pkg.sv
// ----------------------------------------------------------------------------
// pbps_pkg
// Shared types and constants for the push-button power-switch controller.
// ----------------------------------------------------------------------------
package pbps_pkg;

  // Tick counter width (default for the top-level parameter)
  localparam int TICK_BITS_DEF = 20;

  // Configuration register width and register indexes
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLEEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESUME     = 2'd2;

  localparam logic [CFG_W-1:0] ON_DELAY_RST   = 20'd2000;
  localparam logic [CFG_W-1:0] IDLE_SLEEP_RST = 20'd20000;

  // Controller states
  typedef enum logic [3:0] {
    MODE_INIT        = 4'd0,
    MODE_STARTUP     = 4'd1,
    MODE_IDLE        = 4'd2,
    MODE_WAITSLEEP   = 4'd3,
    MODE_SLEEP       = 4'd4,
    MODE_WAITON      = 4'd5,
    MODE_WAITON_INT  = 4'd6,
    MODE_ON          = 4'd7,
    MODE_FETON       = 4'd8,
    MODE_WAITOFF     = 4'd9,
    MODE_WAITOFF_INT = 4'd10,
    MODE_WDTON       = 4'd11
  } mode_t;

  // Button events
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } event_t;

  // Tone player commands
  typedef enum logic [3:0] {
    TONE_NONE      = 4'd0,
    TONE_START     = 4'd1,
    TONE_SLEEP     = 4'd2,
    TONE_WAITON    = 4'd3,
    TONE_WAITOFF   = 4'd4,
    TONE_ON        = 4'd5,
    TONE_OFF       = 4'd6,
    TONE_SHORTBEEP = 4'd7,
    TONE_READY     = 4'd8
  } tone_t;

  // Keep-on flag commands
  typedef enum logic [1:0] {
    KEEP_NONE  = 2'd0,
    KEEP_CLEAR = 2'd1,
    KEEP_SET   = 2'd2
  } keep_t;

endpackage

### rtl/push_button_power_switch_fsm.sv
// ----------------------------------------------------------------------------
// push_button_power_switch_fsm
// Push-button power-switch controller: one tick per transaction in, one
// result (state, switch level, one-shot commands) per transaction out.
// ----------------------------------------------------------------------------
// Each input transaction is one system tick. The block accepts one tick per
// clock cycle while the output register is free; a tick is captured in the
// input register and its result then in the output register, which drives
// out_tdata. The rate is set by the single state update per tick (next-state
// logic, two counter compares). The tick counter saturates at 2^TICK_BITS-1.
// Configuration writes take effect at once and must only be issued while no
// tick is in flight.
module push_button_power_switch_fsm
  import pbps_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // tick input: [1:0] button_event, [2] tone_busy, [7:3] zero
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  // result: [3:0] mode_now, [4] switch_on, [8:5] tone_cmd, [11:9] led_blink,
  //         [12] led_off, [13] sleep_request, [15:14] keep_flag_cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  // Configuration registers
  logic [CFG_W-1:0] on_delay_r;
  logic [CFG_W-1:0] idle_sleep_r;
  logic             resume_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_delay_r   <= ON_DELAY_RST;
      idle_sleep_r <= IDLE_SLEEP_RST;
      resume_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ON_DELAY:   on_delay_r   <= cfg_data;
        CFG_IDLE_SLEEP: idle_sleep_r <= cfg_data;
        CFG_RESUME:     resume_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register and handshake
  logic       in_valid_r;
  event_t     ev_r;
  logic       busy_r;
  logic       out_valid_r;
  logic [15:0] out_data_r;
  logic       out_free;
  logic       advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ev_r   <= event_t'(in_tdata[1:0]);
      busy_r <= in_tdata[2];
    end
  end

  // Controller state
  mode_t                mode_r, mode_nxt;
  logic [TICK_BITS-1:0] ticks_r, ticks_nxt;
  logic                 switch_r, switch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_INIT;
      ticks_r  <= '0;
      switch_r <= 1'b0;
    end else if (advance) begin
      mode_r   <= mode_nxt;
      ticks_r  <= ticks_nxt;
      switch_r <= switch_nxt;
    end
  end

  // Next state and commands for the tick in the input register
  mode_t                cur;
  mode_t                nxt;
  logic [TICK_BITS-1:0] ticks_inc;
  logic [CMP_W-1:0]     ticks_cmp;
  logic                 idle_expired;
  logic                 on_expired;
  tone_t                tone;
  logic [2:0]           blink;
  logic                 ledoff;
  logic                 sleepreq;
  keep_t                keep;
  logic [15:0]          out_data_nxt;

  always_comb begin
    cur          = (mode_r == MODE_INIT && resume_r) ? MODE_WDTON : mode_r;
    ticks_inc    = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 1'b1;
    ticks_cmp    = CMP_W'(ticks_inc);
    idle_expired = ticks_cmp > CMP_W'(idle_sleep_r);
    on_expired   = ticks_cmp > CMP_W'(on_delay_r);
    nxt          = cur;
    switch_nxt   = switch_r;
    tone         = TONE_NONE;
    blink        = 3'd0;
    ledoff       = 1'b0;
    sleepreq     = 1'b0;
    keep         = KEEP_NONE;

    // transition conditions
    case (cur)
      MODE_INIT: begin
        switch_nxt = 1'b0;
        tone       = TONE_START;
        nxt        = MODE_STARTUP;
      end
      MODE_WDTON:     nxt = MODE_FETON;
      MODE_STARTUP:   if (!busy_r) nxt = MODE_IDLE;
      MODE_IDLE: begin
        if (idle_expired)          nxt = MODE_WAITSLEEP;
        else if (ev_r == EV_SHORT) nxt = MODE_WAITON;
      end
      MODE_WAITSLEEP: if (!busy_r) nxt = MODE_SLEEP;
      MODE_SLEEP:     if (ev_r == EV_SHORT) nxt = MODE_WAITON;
      MODE_WAITON: begin
        if (ev_r == EV_LONG)         nxt = MODE_ON;
        else if (ev_r == EV_RELEASE) nxt = MODE_WAITON_INT;
      end
      MODE_WAITON_INT: nxt = MODE_IDLE;
      MODE_ON: begin
        // short press wins over the on-delay timeout
        if (ev_r == EV_SHORT)  nxt = MODE_WAITOFF;
        else if (on_expired)   nxt = MODE_FETON;
      end
      MODE_FETON:     if (ev_r == EV_SHORT) nxt = MODE_WAITOFF;
      MODE_WAITOFF: begin
        if (ev_r == EV_LONG)         nxt = MODE_IDLE;
        else if (ev_r == EV_RELEASE) nxt = MODE_WAITOFF_INT;
      end
      MODE_WAITOFF_INT: nxt = MODE_ON;
      default: ;
    endcase

    mode_nxt  = cur;
    ticks_nxt = ticks_inc;

    // entry actions on a change of state
    if (nxt != cur) begin
      ticks_nxt = '0;
      mode_nxt  = nxt;
      case (nxt)
        MODE_STARTUP: switch_nxt = 1'b0;
        MODE_WAITSLEEP: begin
          ledoff = 1'b1;
          tone   = TONE_SLEEP;
        end
        MODE_SLEEP: begin
          // sleep is transient: go to Idle without Idle's entry actions
          switch_nxt = 1'b0;
          keep       = KEEP_CLEAR;
          ledoff     = 1'b1;
          sleepreq   = 1'b1;
          mode_nxt   = MODE_IDLE;
        end
        MODE_WAITON: begin
          tone  = TONE_WAITON;
          blink = 3'd2;
        end
        MODE_WAITON_INT, MODE_WAITOFF_INT: tone = TONE_SHORTBEEP;
        MODE_ON: begin
          if (cur != MODE_WAITOFF_INT) tone = TONE_ON;
          blink = 3'd4;
        end
        MODE_FETON: begin
          if (!busy_r && cur != MODE_WDTON) tone = TONE_READY;
          blink      = 3'd5;
          switch_nxt = 1'b1;
          keep       = KEEP_SET;
        end
        MODE_WAITOFF: begin
          blink = 3'd3;
          tone  = TONE_WAITOFF;
        end
        MODE_IDLE: begin
          if (cur != MODE_WAITON_INT) tone = TONE_OFF;
          blink      = 3'd1;
          switch_nxt = 1'b0;
          keep       = KEEP_CLEAR;
        end
        default: ;
      endcase
    end

    out_data_nxt = {keep, sleepreq, ledoff, blink, tone, switch_nxt, mode_nxt};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### dv/push_button_power_switch_fsm_tb.sv
// ----------------------------------------------------------------------------
// push_button_power_switch_fsm_tb
// Self-checking bench for the push-button power-switch controller. Ticks are
// queued per register setting, driven with random gaps, and every result is
// checked field by field against a cycle-free model of the state machine.
// ----------------------------------------------------------------------------
module push_button_power_switch_fsm_tb;
  import pbps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  // One tick as it sits in tdata, lowest field in the lowest bits
  typedef struct packed {
    logic   busy;
    event_t ev;
  } tick_t;

  // One result, laid out as out_tdata
  typedef struct packed {
    keep_t       keep;
    logic        sleep_req;
    logic        led_off;
    logic [2:0]  blink;
    tone_t       tone;
    logic        sw;
    mode_t       mode;
  } ctl_out_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // [1:0] button_event, [2] tone_busy
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;       // [3:0] mode, [4] switch, [8:5] tone,
                                         // [11:9] blink, [12] led_off,
                                         // [13] sleep_req, [15:14] keep_flag
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  push_button_power_switch_fsm u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state and its copy of the registers
  mode_t                    ctl_mode;
  logic [TICK_BITS_DEF-1:0] ctl_ticks;
  logic                     ctl_switch;
  logic [CFG_W-1:0]         on_delay_lim;
  logic [CFG_W-1:0]         idle_sleep_lim;
  logic                     ctl_resume;

  tick_t    ticks_to_send[$];
  ctl_out_t results_due[$];

  int errors = 0;
  int ticks_queued = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int settings_run = 0;
  int input_stalls = 0;
  int long_holds = 0;
  int quiet_cycles = 0;
  logic [15:0] states_seen = '0;

  // Controller model: one tick in, returns the result it produces
  function automatic ctl_out_t step_controller(tick_t t);
    mode_t    last;
    mode_t    nxt;
    ctl_out_t r;
    r = '0;
    // a set resume flag makes the first tick out of Init a watchdog restart
    if (ctl_mode == MODE_INIT && ctl_resume) ctl_mode = MODE_WDTON;
    last = ctl_mode;
    nxt  = ctl_mode;
    if (ctl_ticks != '1) ctl_ticks = ctl_ticks + 1'b1;

    // next-state decision
    case (ctl_mode)
      MODE_INIT: begin
        ctl_switch = 1'b0;
        r.tone     = TONE_START;
        nxt        = MODE_STARTUP;
      end
      MODE_WDTON:   nxt = MODE_FETON;
      MODE_STARTUP: if (!t.busy) nxt = MODE_IDLE;
      MODE_IDLE: begin
        // expiry beats a short press on the same tick
        if (ctl_ticks > idle_sleep_lim) nxt = MODE_WAITSLEEP;
        else if (t.ev == EV_SHORT)      nxt = MODE_WAITON;
      end
      MODE_WAITSLEEP: if (!t.busy) nxt = MODE_SLEEP;
      MODE_SLEEP:     if (t.ev == EV_SHORT) nxt = MODE_WAITON;
      MODE_WAITON: begin
        if (t.ev == EV_LONG)         nxt = MODE_ON;
        else if (t.ev == EV_RELEASE) nxt = MODE_WAITON_INT;
      end
      MODE_WAITON_INT: nxt = MODE_IDLE;
      MODE_ON: begin
        // short press overrides the on-delay expiry
        if (ctl_ticks > on_delay_lim) nxt = MODE_FETON;
        if (t.ev == EV_SHORT)         nxt = MODE_WAITOFF;
      end
      MODE_FETON: if (t.ev == EV_SHORT) nxt = MODE_WAITOFF;
      MODE_WAITOFF: begin
        if (t.ev == EV_LONG)         nxt = MODE_IDLE;
        else if (t.ev == EV_RELEASE) nxt = MODE_WAITOFF_INT;
      end
      MODE_WAITOFF_INT: nxt = MODE_ON;
      default: ;
    endcase

    // entry actions
    if (nxt != last) begin
      ctl_ticks = '0;
      case (nxt)
        MODE_STARTUP: ctl_switch = 1'b0;
        MODE_WAITSLEEP: begin
          r.led_off = 1'b1;
          r.tone    = TONE_SLEEP;
        end
        MODE_SLEEP: begin
          // sleep falls straight through to Idle, skipping Idle's entry
          ctl_switch  = 1'b0;
          r.keep      = KEEP_CLEAR;
          r.led_off   = 1'b1;
          r.sleep_req = 1'b1;
          nxt         = MODE_IDLE;
        end
        MODE_WAITON: begin
          r.tone  = TONE_WAITON;
          r.blink = 3'd2;
        end
        MODE_WAITON_INT, MODE_WAITOFF_INT: r.tone = TONE_SHORTBEEP;
        MODE_ON: begin
          if (last != MODE_WAITOFF_INT) r.tone = TONE_ON;
          r.blink = 3'd4;
        end
        MODE_FETON: begin
          if (!t.busy && last != MODE_WDTON) r.tone = TONE_READY;
          r.blink    = 3'd5;
          ctl_switch = 1'b1;
          r.keep     = KEEP_SET;
        end
        MODE_WAITOFF: begin
          r.blink = 3'd3;
          r.tone  = TONE_WAITOFF;
        end
        MODE_IDLE: begin
          if (last != MODE_WAITON_INT) r.tone = TONE_OFF;
          r.blink    = 3'd1;
          ctl_switch = 1'b0;
          r.keep     = KEEP_CLEAR;
        end
        default: ;
      endcase
      ctl_mode = nxt;
    end

    r.mode = ctl_mode;
    r.sw   = ctl_switch;
    return r;
  endfunction

  // Per-transaction wait, with occasional runs of back-to-back traffic
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 16);
  endfunction

  task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Tick driver
  int send_wait = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && !in_tready) input_stalls++;
      if (in_tvalid && in_tready) begin
        ctl_out_t r;
        r = step_controller(tick_t'(in_tdata[2:0]));
        states_seen[r.mode] = 1'b1;
        results_due.push_back(r);
        ticks_sent++;
        send_wait = draw_gap(send_calm);
      end
      // load the next tick unless the current one is still waiting
      if (!(in_tvalid && !in_tready)) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          in_tdata  <= {5'd0, ticks_to_send.pop_front()};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker
  int recv_wait = 0;
  int recv_calm = 0;
  int hold_left = 0;

  always @(posedge clk) begin : result_monitor
    ctl_out_t want;
    ctl_out_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = ctl_out_t'(out_tdata);
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("mode_now", want.mode, got.mode);
          check_field("switch_on", want.sw, got.sw);
          check_field("tone_cmd", want.tone, got.tone);
          check_field("led_blink", want.blink, got.blink);
          check_field("led_off", want.led_off, got.led_off);
          check_field("sleep_request", want.sleep_req, got.sleep_req);
          check_field("keep_flag_cmd", want.keep, got.keep);
        end
        results_checked++;
        // now and then a long hold-off so the block backs up into its input
        if (results_checked % 250 == 100) begin
          hold_left = $urandom_range(48, 96);
          long_holds++;
        end else begin
          recv_wait = draw_gap(recv_calm);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write, mirrored into the model at once (nothing in flight)
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_ON_DELAY:   on_delay_lim   = data;
      CFG_IDLE_SLEEP: idle_sleep_lim = data;
      CFG_RESUME:     ctl_resume     = data[0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic put_tick(event_t ev, logic busy);
    tick_t t;
    t.ev   = ev;
    t.busy = busy;
    ticks_to_send.push_back(t);
    ticks_queued++;
  endtask

  // Walk through every state and entry action (tuned for delays of 3 and 4)
  task automatic queue_directed_ticks();
    put_tick(EV_NONE, 1'b1);      // leave Init: Startup, or FetOn on resume
    put_tick(EV_NONE, 1'b1);      // Startup holds while the tone plays
    put_tick(EV_NONE, 1'b0);
    put_tick(EV_SHORT, 1'b0);     // Idle -> WaitOn
    put_tick(EV_RELEASE, 1'b1);   // released early
    put_tick(EV_NONE, 1'b0);      // back to Idle without the off tone
    put_tick(EV_SHORT, 1'b1);
    put_tick(EV_LONG, 1'b0);      // WaitOn -> On
    put_tick(EV_SHORT, 1'b0);     // On -> WaitOff
    put_tick(EV_RELEASE, 1'b0);
    put_tick(EV_NONE, 1'b0);      // back to On without the on tone
    repeat (4) put_tick(EV_NONE, 1'b0);  // on-delay runs out, ready note
    put_tick(EV_SHORT, 1'b1);
    put_tick(EV_LONG, 1'b1);      // WaitOff -> Idle
    repeat (4) put_tick(EV_NONE, 1'b1);
    put_tick(EV_SHORT, 1'b1);     // idle expiry wins over the press
    put_tick(EV_LONG, 1'b1);      // WaitSleep holds while busy
    put_tick(EV_NONE, 1'b0);      // sleep request, straight to Idle
    put_tick(EV_SHORT, 1'b0);
  endtask

  // Mostly press gestures and quiet stretches, some noise
  task automatic queue_random_ticks(int n);
    int target;
    int len;
    target = ticks_queued + n;
    while (ticks_queued < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 8);
          repeat (len) put_tick(event_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        2, 3: begin
          len = $urandom_range(1, 40);
          repeat (len) put_tick(EV_NONE, $urandom_range(0, 3) == 0);
        end
        4, 5, 6, 7: begin
          put_tick(EV_SHORT, 1'($urandom_range(0, 1)));
          len = $urandom_range(0, 3);
          repeat (len) put_tick(EV_NONE, 1'($urandom_range(0, 1)));
          put_tick($urandom_range(0, 4) == 0 ? EV_RELEASE : EV_LONG,
                   1'($urandom_range(0, 1)));
        end
        default: begin
          len = $urandom_range(1, 10);
          repeat (len) put_tick(EV_NONE, 1'b1);
        end
      endcase
    end
  endtask

  // Sender holds back until every result is in
  task automatic wait_drained();
    while (ticks_to_send.size() != 0 || in_tvalid || results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_setting(logic [CFG_W-1:0] on_delay, logic [CFG_W-1:0] idle_sleep,
                             logic resume, int n, bit directed);
    write_register(CFG_ON_DELAY, on_delay);
    write_register(CFG_IDLE_SLEEP, idle_sleep);
    write_register(CFG_RESUME, {19'($urandom), resume});
    settings_run++;
    if (directed) queue_directed_ticks();
    queue_random_ticks(n);
    wait_drained();
  endtask

  initial begin
    logic first_resume;
    ctl_mode       = MODE_INIT;
    ctl_ticks      = '0;
    ctl_switch     = 1'b0;
    on_delay_lim   = ON_DELAY_RST;
    idle_sleep_lim = IDLE_SLEEP_RST;
    ctl_resume     = 1'b0;
    first_resume   = 1'($urandom_range(0, 1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_setting(20'd3, 20'd4, first_resume, 275, 1'b1);
    run_setting(20'd0, 20'd0, !first_resume, 250, 1'b0);
    run_setting(20'hFFFFF, 20'hFFFFF, 1'b0, 150, 1'b0);
    run_setting(20'($urandom_range(0, 40)), 20'($urandom_range(0, 40)),
                1'($urandom_range(0, 1)), 300, 1'b0);
    run_setting(20'd1, 20'd1, 1'b1, 200, 1'b0);
    write_register(CFG_UNUSED, 20'($urandom));
    run_setting(20'($urandom_range(0, 60)), 20'($urandom_range(0, 60)),
                1'($urandom_range(0, 1)), 325, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      errors++;
    end

    $display("Covered %0d ticks and %0d checked results over %0d register settings (%0d writes).",
             ticks_sent, results_checked, settings_run, reg_writes);
    $display("Reported %0d distinct states; %0d input stall cycles, %0d long output hold-offs.",
             $countones(states_seen), input_stalls, long_holds);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pbps_pkg.sv
rtl/push_button_power_switch_fsm.sv
dv/push_button_power_switch_fsm_tb.sv
